### rtl/lcdnb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lcdnb_pkg;

	typedef enum logic [2:0] {
		CMD_INIT   = 3'd0,
		CMD_CLEAR  = 3'd1,
		CMD_CURSOR = 3'd2,
		CMD_CHAR   = 3'd3,
		CMD_NUMBER = 3'd4,
		CMD_RAW    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_ONE,
		F_INIT,
		F_MOD,
		F_DIGIT
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SHOW,
		B_WAIT
	} back_state_t;

	// six bus phases of one byte, high nibble first
	typedef enum logic [2:0] {
		PH_HI_SETUP,
		PH_HI_STROBE,
		PH_HI_HOLD,
		PH_LO_SETUP,
		PH_LO_STROBE,
		PH_LO_HOLD
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       rs;
		logic       long_hold;
		logic       last;
	} lcdnb_entry_t;

	typedef struct packed {
		logic         valid;
		lcdnb_entry_t entry;
	} lcdnb_push_t;

	typedef struct packed {
		logic       strobe;
		logic       reg_sel;
		logic [3:0] nibble;
		logic       enable;
		logic [1:0] hold;
		logic       last;
	} lcdnb_pins_t;

	localparam int          DELAY_W       = 24;
	localparam int          TIMER_W       = DELAY_W + 1;
	localparam logic [23:0] DELAY_RESET   = 24'd25000;
	localparam logic [2:0]  INIT_LAST_IDX = 3'd5;
	localparam logic [2:0]  DIGIT_LAST    = 3'd3;
	localparam logic [7:0]  CLEAR_BYTE    = 8'h01;
	localparam logic [7:0]  ASCII_ZERO    = 8'd48;
	localparam logic [15:0] NUM_MODULUS   = 16'd10000;
	localparam logic [1:0]  HOLD_SHORT    = 2'd1;
	localparam logic [1:0]  HOLD_LONG     = 2'd2;

	function automatic logic [7:0] init_byte(input logic [2:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = 8'h33;
			3'd1:    b = 8'h32;
			3'd2:    b = 8'h28;
			3'd3:    b = 8'h0C;
			3'd4:    b = 8'h06;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] line_offset(input logic [1:0] ln);
		logic [7:0] o;
		unique case (ln)
			2'd0:    o = 8'h00;
			2'd1:    o = 8'h40;
			2'd2:    o = 8'h10;
			default: o = 8'h50;
		endcase
		return o;
	endfunction

	function automatic logic [15:0] digit_place(input logic [1:0] p);
		logic [15:0] v;
		unique case (p)
			2'd0:    v = 16'd1000;
			2'd1:    v = 16'd100;
			2'd2:    v = 16'd10;
			default: v = 16'd1;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/lcdnb_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdnb_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire  [2:0]           command,
	input  wire  [7:0]           byte_value,
	input  wire                  rs_select,
	input  wire  [6:0]           cursor_pos,
	input  wire  [2:0]           line,
	input  wire  [15:0]          number,
	input  wire                  full,
	output lcdnb_pkg::lcdnb_push_t push,
	output logic                 busy
);

	lcdnb_pkg::front_state_t state_q, state_d;
	logic [7:0]  byte_q, byte_d;
	logic        rs_q, rs_d;
	logic        long_q, long_d;
	logic [2:0]  idx_q, idx_d;
	logic [15:0] val_q, val_d;
	logic [3:0]  digit_q, digit_d;
	logic [15:0] place;

	assign place = lcdnb_pkg::digit_place(idx_q[1:0]);

	always_comb begin
		state_d = state_q;
		byte_d  = byte_q;
		rs_d    = rs_q;
		long_d  = long_q;
		idx_d   = idx_q;
		val_d   = val_q;
		digit_d = digit_q;
		unique case (state_q)
			lcdnb_pkg::F_IDLE: begin
				if (accept) begin
					unique case (lcdnb_pkg::cmd_t'(command))
						lcdnb_pkg::CMD_INIT: begin
							idx_d   = 3'd0;
							state_d = lcdnb_pkg::F_INIT;
						end
						lcdnb_pkg::CMD_CLEAR: begin
							byte_d  = lcdnb_pkg::CLEAR_BYTE;
							rs_d    = 1'b0;
							long_d  = 1'b0;
							state_d = lcdnb_pkg::F_ONE;
						end
						lcdnb_pkg::CMD_CURSOR: begin
							if (!line[2]) begin
								byte_d  = {1'b1, cursor_pos} + lcdnb_pkg::line_offset(line[1:0]);
								rs_d    = 1'b0;
								long_d  = 1'b1;
								state_d = lcdnb_pkg::F_ONE;
							end
						end
						lcdnb_pkg::CMD_CHAR: begin
							byte_d  = byte_value;
							rs_d    = 1'b1;
							long_d  = 1'b0;
							state_d = lcdnb_pkg::F_ONE;
						end
						lcdnb_pkg::CMD_NUMBER: begin
							val_d   = number;
							idx_d   = 3'd0;
							digit_d = 4'd0;
							state_d = lcdnb_pkg::F_MOD;
						end
						lcdnb_pkg::CMD_RAW: begin
							byte_d  = byte_value;
							rs_d    = rs_select;
							long_d  = 1'b0;
							state_d = lcdnb_pkg::F_ONE;
						end
						default: ;
					endcase
				end
			end
			lcdnb_pkg::F_ONE: begin
				if (!full) state_d = lcdnb_pkg::F_IDLE;
			end
			lcdnb_pkg::F_INIT: begin
				if (!full) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == lcdnb_pkg::INIT_LAST_IDX) state_d = lcdnb_pkg::F_IDLE;
				end
			end
			lcdnb_pkg::F_MOD: begin
				// strip whole multiples of ten thousand, one per cycle
				if (val_q >= lcdnb_pkg::NUM_MODULUS) val_d = val_q - lcdnb_pkg::NUM_MODULUS;
				else state_d = lcdnb_pkg::F_DIGIT;
			end
			lcdnb_pkg::F_DIGIT: begin
				if (val_q >= place) begin
					val_d   = val_q - place;
					digit_d = digit_q + 4'd1;
				end else if (!full) begin
					digit_d = 4'd0;
					idx_d   = idx_q + 3'd1;
					if (idx_q == lcdnb_pkg::DIGIT_LAST) state_d = lcdnb_pkg::F_IDLE;
				end
			end
			default: state_d = lcdnb_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		push = '0;
		busy = (state_q != lcdnb_pkg::F_IDLE);
		unique case (state_q)
			lcdnb_pkg::F_ONE: begin
				push.valid           = 1'b1;
				push.entry.data      = byte_q;
				push.entry.rs        = rs_q;
				push.entry.long_hold = long_q;
				push.entry.last      = 1'b1;
			end
			lcdnb_pkg::F_INIT: begin
				push.valid           = 1'b1;
				push.entry.data      = lcdnb_pkg::init_byte(idx_q);
				push.entry.rs        = 1'b0;
				push.entry.long_hold = 1'b1;
				push.entry.last      = (idx_q == lcdnb_pkg::INIT_LAST_IDX);
			end
			lcdnb_pkg::F_DIGIT: begin
				push.valid           = (val_q < place);
				push.entry.data      = lcdnb_pkg::ASCII_ZERO | {4'd0, digit_q};
				push.entry.rs        = 1'b1;
				push.entry.long_hold = 1'b0;
				push.entry.last      = (idx_q == lcdnb_pkg::DIGIT_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcdnb_pkg::F_IDLE;
			idx_q   <= 3'd0;
			digit_q <= 4'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			digit_q <= digit_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
		rs_q   <= rs_d;
		long_q <= long_d;
		val_q  <= val_d;
	end

endmodule

`default_nettype wire

### rtl/lcdnb_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdnb_queue #(
	parameter int DEPTH = 4
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  lcdnb_pkg::lcdnb_push_t push,
	output logic                   full,
	input  wire                    pop,
	output logic                   empty,
	output lcdnb_pkg::lcdnb_entry_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	lcdnb_pkg::lcdnb_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push.entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/lcdnb_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lcdnb_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire  [23:0]             delay,
	input  wire                     empty,
	input  lcdnb_pkg::lcdnb_entry_t head,
	output logic                    pop,
	output lcdnb_pkg::lcdnb_pins_t  pins,
	output logic                    busy
);

	lcdnb_pkg::back_state_t state_q, state_d;
	lcdnb_pkg::phase_t      phase_q, phase_next;
	lcdnb_pkg::lcdnb_entry_t cur_q;
	logic [lcdnb_pkg::TIMER_W-1:0] timer_q, timer_load;
	logic long_now, timer_done;

	assign long_now   = cur_q.long_hold && (phase_q == lcdnb_pkg::PH_LO_HOLD);
	assign timer_load = long_now ? {delay, 1'b0} : {1'b0, delay};
	assign timer_done = (timer_q <= lcdnb_pkg::TIMER_W'(1));

	always_comb begin
		unique case (phase_q)
			lcdnb_pkg::PH_HI_SETUP:  phase_next = lcdnb_pkg::PH_HI_STROBE;
			lcdnb_pkg::PH_HI_STROBE: phase_next = lcdnb_pkg::PH_HI_HOLD;
			lcdnb_pkg::PH_HI_HOLD:   phase_next = lcdnb_pkg::PH_LO_SETUP;
			lcdnb_pkg::PH_LO_SETUP:  phase_next = lcdnb_pkg::PH_LO_STROBE;
			lcdnb_pkg::PH_LO_STROBE: phase_next = lcdnb_pkg::PH_LO_HOLD;
			default:                 phase_next = lcdnb_pkg::PH_HI_SETUP;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcdnb_pkg::B_IDLE: if (!empty) state_d = lcdnb_pkg::B_SHOW;
			lcdnb_pkg::B_SHOW: state_d = lcdnb_pkg::B_WAIT;
			lcdnb_pkg::B_WAIT: begin
				if (timer_done) begin
					state_d = (phase_q == lcdnb_pkg::PH_LO_HOLD) ? lcdnb_pkg::B_IDLE
						: lcdnb_pkg::B_SHOW;
				end
			end
			default: state_d = lcdnb_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop          = (state_q == lcdnb_pkg::B_IDLE) && !empty;
		busy         = (state_q != lcdnb_pkg::B_IDLE);
		pins.strobe  = (state_q == lcdnb_pkg::B_SHOW);
		pins.reg_sel = cur_q.rs;
		pins.nibble  = (phase_q == lcdnb_pkg::PH_HI_SETUP || phase_q == lcdnb_pkg::PH_HI_STROBE
			|| phase_q == lcdnb_pkg::PH_HI_HOLD) ? cur_q.data[7:4] : cur_q.data[3:0];
		pins.enable  = (phase_q == lcdnb_pkg::PH_HI_STROBE)
			|| (phase_q == lcdnb_pkg::PH_LO_STROBE);
		pins.hold    = long_now ? lcdnb_pkg::HOLD_LONG : lcdnb_pkg::HOLD_SHORT;
		pins.last    = cur_q.last && (phase_q == lcdnb_pkg::PH_LO_HOLD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcdnb_pkg::B_IDLE;
			phase_q <= lcdnb_pkg::PH_HI_SETUP;
			timer_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				lcdnb_pkg::B_IDLE: phase_q <= lcdnb_pkg::PH_HI_SETUP;
				lcdnb_pkg::B_SHOW: timer_q <= timer_load;
				lcdnb_pkg::B_WAIT: begin
					if (timer_done) phase_q <= phase_next;
					else timer_q <= timer_q - lcdnb_pkg::TIMER_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

endmodule

`default_nettype wire

### rtl/char_lcd_nibble_bus_driver_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// request   | start, busy          | command, byte_value, rs_select, cursor_pos,
//           |                      | line, number
// phase out | strobe               | reg_sel, data_nibble, enable, hold_periods, last
// config    | cfg_we               | cfg_wdata (phase_delay_cycles)
//
// A request is taken when start is high and busy is low; one request is in
// work at a time. The first phase strobes after the request passes the
// front-end state, the queue and the back-end state; a number must first be
// stripped of multiples of ten thousand and its first digit found. Each bus
// phase is shown for one cycle under strobe and then held by the back-end
// timer for a span that hold_periods and phase_delay_cycles set, after which the
// next queued byte is popped; init sends six bytes, numbers four. Busy drops the
// cycle after the final hold ends. The receiver cannot stall; arst_n clears all
// control state and the delay register returns to 25000.

module char_lcd_nibble_bus_driver_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  command,
	input  wire  [7:0]  byte_value,
	input  wire         rs_select,
	input  wire  [6:0]  cursor_pos,
	input  wire  [2:0]  line,
	input  wire  [15:0] number,
	input  wire         cfg_we,
	input  wire  [23:0] cfg_wdata,
	output logic        strobe,
	output logic        reg_sel,
	output logic [3:0]  data_nibble,
	output logic        enable,
	output logic [1:0]  hold_periods,
	output logic        last
);

	logic [23:0] phase_delay_q;
	logic        accept;
	logic        front_busy, back_busy;
	logic        full, empty, pop;
	lcdnb_pkg::lcdnb_push_t  push;
	lcdnb_pkg::lcdnb_entry_t head;
	lcdnb_pkg::lcdnb_pins_t  pins;

	// hold the delay register; the user must change it only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= lcdnb_pkg::DELAY_RESET;
		end else if (cfg_we) begin
			phase_delay_q <= cfg_wdata;
		end
	end

	// busy covers the front end, queued bytes and the byte on the bus
	assign busy   = front_busy || !empty || back_busy;
	assign accept = start && !busy;

	// front end: decode the request into a list of bytes
	lcdnb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.command    (command),
		.byte_value (byte_value),
		.rs_select  (rs_select),
		.cursor_pos (cursor_pos),
		.line       (line),
		.number     (number),
		.full       (full),
		.push       (push),
		.busy       (front_busy)
	);

	// short byte queue between decode and bus timing
	lcdnb_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.pop    (pop),
		.empty  (empty),
		.head   (head)
	);

	// back end: split each byte into six timed bus phases
	lcdnb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.delay  (phase_delay_q),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.pins   (pins),
		.busy   (back_busy)
	);

	assign strobe       = pins.strobe;
	assign reg_sel      = pins.reg_sel;
	assign data_nibble  = pins.nibble;
	assign enable       = pins.enable;
	assign hold_periods = pins.hold;
	assign last         = pins.last;

endmodule

`default_nettype wire

### dv/char_lcd_nibble_bus_driver_top_tb.sv
`timescale 1ns / 1ps

module char_lcd_nibble_bus_driver_top_tb;
	import lcdnb_pkg::*;

	// command codes that the block does not know; they must produce no phases
	localparam logic [2:0]  CMD_SPARE_6 = 3'd6;
	localparam logic [2:0]  CMD_SPARE_7 = 3'd7;
	localparam logic [23:0] DELAY_MIN   = 24'd1;
	localparam logic [23:0] DELAY_MAX   = 24'hFFFFFF;
	localparam int          RANDOM_REQS = 78;
	localparam int          CYCLE_LIMIT = 2_000_000;
	localparam int          N_DIRECTED  = 22;

	// power-up byte sequence and DDRAM line bases, kept apart from the package
	localparam logic [7:0] POWER_UP_SEQ [6] = '{8'h33, 8'h32, 8'h28, 8'h0C, 8'h06, 8'h01};
	localparam logic [7:0] DDRAM_BASE [4]   = '{8'h00, 8'h40, 8'h10, 8'h50};

	typedef struct packed {
		logic       reg_sel;
		logic [3:0] nibble;
		logic       enable;
		logic [1:0] hold;
		logic       last;
	} bus_phase_t;

	// one request; when hand_typed is set the byte to expect is given in the row
	typedef struct packed {
		logic [2:0]  cmd;
		logic [7:0]  byte_v;
		logic        rs;
		logic [6:0]  pos;
		logic [2:0]  ln;
		logic [15:0] num;
		logic        hand_typed;
		logic        has_byte;
		logic [7:0]  t_byte;
		logic        t_rs;
		logic        t_long;
	} lcd_request_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  command;
	logic [7:0]  byte_value;
	logic        rs_select;
	logic [6:0]  cursor_pos;
	logic [2:0]  line;
	logic [15:0] number;
	logic        cfg_we;
	logic [23:0] cfg_wdata;
	logic        strobe;
	logic        reg_sel;
	logic [3:0]  data_nibble;
	logic        enable;
	logic [1:0]  hold_periods;
	logic        last;

	bus_phase_t pending_phases[$];
	int         mismatch_count;
	int         cycle_count;
	int         cur_delay;
	int         burst_left;

	lcd_request_t directed_rows [N_DIRECTED] = '{
		// clear right after reset: RS 0, byte 0x01, short holds
		'{CMD_CLEAR,  8'hFF, 1'b1, 7'h7F, 3'd7, 16'hFFFF, 1'b1, 1'b1, 8'h01, 1'b0, 1'b0},
		'{CMD_INIT,   8'h00, 1'b0, 7'h00, 3'd0, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		// home position on line 0: 0x80 with a long final hold
		'{CMD_CURSOR, 8'h00, 1'b0, 7'h00, 3'd0, 16'h0000, 1'b1, 1'b1, 8'h80, 1'b0, 1'b1},
		'{CMD_CURSOR, 8'h00, 1'b0, 7'h7F, 3'd1, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_CURSOR, 8'h00, 1'b0, 7'h7F, 3'd3, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_CURSOR, 8'h00, 1'b0, 7'h05, 3'd2, 16'h0000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		// lines past 3 send nothing
		'{CMD_CURSOR, 8'hFF, 1'b1, 7'h7F, 3'd4, 16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_CURSOR, 8'h00, 1'b0, 7'h00, 3'd7, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_CHAR,   8'h00, 1'b0, 7'h00, 3'd0, 16'h0000, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
		'{CMD_CHAR,   8'hFF, 1'b0, 7'h7F, 3'd7, 16'hFFFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
		'{CMD_NUMBER, 8'h00, 1'b0, 7'h00, 3'd0, 16'd0,    1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_NUMBER, 8'h00, 1'b0, 7'h00, 3'd0, 16'd9999, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_NUMBER, 8'h00, 1'b0, 7'h00, 3'd0, 16'd10000, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_NUMBER, 8'h00, 1'b0, 7'h00, 3'd0, 16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_NUMBER, 8'h00, 1'b0, 7'h00, 3'd0, 16'd1234, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_RAW,    8'h00, 1'b0, 7'h7F, 3'd7, 16'hFFFF, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0},
		'{CMD_RAW,    8'hFF, 1'b1, 7'h00, 3'd0, 16'h0000, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0},
		'{CMD_RAW,    8'hA5, 1'b1, 7'h2A, 3'd5, 16'h5A5A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		// unknown commands send nothing
		'{CMD_SPARE_6, 8'hFF, 1'b1, 7'h7F, 3'd0, 16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_SPARE_7, 8'h00, 1'b0, 7'h00, 3'd1, 16'h0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_CHAR,   8'h5A, 1'b1, 7'h55, 3'd2, 16'hA5A5, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
		'{CMD_CLEAR,  8'h3C, 1'b1, 7'h2B, 3'd6, 16'h1357, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	char_lcd_nibble_bus_driver_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.command      (command),
		.byte_value   (byte_value),
		.rs_select    (rs_select),
		.cursor_pos   (cursor_pos),
		.line         (line),
		.number       (number),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.strobe       (strobe),
		.reg_sel      (reg_sel),
		.data_nibble  (data_nibble),
		.enable       (enable),
		.hold_periods (hold_periods),
		.last         (last)
	);

	always #4 clk = ~clk;

	// Queue the six bus phases of one byte: set up, strobe E, drop E, per nibble.
	task automatic queue_byte_phases(input logic [7:0] b, input logic rs, input logic long_end);
		bus_phase_t ph;
		for (int i = 0; i < 6; i++) begin
			ph.reg_sel = rs;
			ph.nibble  = (i < 3) ? b[7:4] : b[3:0];
			ph.enable  = (i == 1 || i == 4);
			ph.hold    = (i == 5 && long_end) ? HOLD_LONG : HOLD_SHORT;
			ph.last    = 1'b0;
			pending_phases.push_back(ph);
		end
	endtask

	// Work out the bytes one request puts on the bus.
	task automatic predict_bus_bytes(input lcd_request_t r);
		logic [13:0] val;
		logic [7:0]  addr;
		case (r.cmd)
			CMD_INIT: begin
				for (int i = 0; i < 6; i++)
					queue_byte_phases(POWER_UP_SEQ[i], 1'b0, 1'b1);
			end
			CMD_CLEAR: queue_byte_phases(8'h01, 1'b0, 1'b0);
			CMD_CURSOR: begin
				if (r.ln < 3'd4) begin
					addr = {1'b1, r.pos} + DDRAM_BASE[r.ln[1:0]];
					queue_byte_phases(addr, 1'b0, 1'b1);
				end
			end
			CMD_CHAR: queue_byte_phases(r.byte_v, 1'b1, 1'b0);
			CMD_NUMBER: begin
				val = 14'(r.num % 16'd10000);
				queue_byte_phases(8'd48 + 8'(val / 1000), 1'b1, 1'b0);
				queue_byte_phases(8'd48 + 8'((val / 100) % 10), 1'b1, 1'b0);
				queue_byte_phases(8'd48 + 8'((val / 10) % 10), 1'b1, 1'b0);
				queue_byte_phases(8'd48 + 8'(val % 10), 1'b1, 1'b0);
			end
			CMD_RAW: queue_byte_phases(r.byte_v, r.rs, 1'b0);
			default: ;
		endcase
	endtask

	// Present one request, hold it until taken, then either keep start high for the
	// next one of the burst or drop it for a random gap.
	task automatic send_request(input lcd_request_t r, output int n_phases);
		int         queued_prior;
		bus_phase_t tail;
		start      <= 1'b1;
		command    <= r.cmd;
		byte_value <= r.byte_v;
		rs_select  <= r.rs;
		cursor_pos <= r.pos;
		line       <= r.ln;
		number     <= r.num;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		queued_prior = pending_phases.size();
		if (r.hand_typed) begin
			if (r.has_byte)
				queue_byte_phases(r.t_byte, r.t_rs, r.t_long);
		end else begin
			predict_bus_bytes(r);
		end
		n_phases = pending_phases.size() - queued_prior;
		// flag the closing phase of this request
		if (n_phases > 0) begin
			tail = pending_phases.pop_back();
			tail.last = 1'b1;
			pending_phases.push_back(tail);
		end
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			// now and then run a long back-to-back stretch
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
				: $urandom_range(0, 5);
		end
	endtask

	// Drain all expected phases, wait for the block to go idle, then let the last
	// hold run out before touching the delay register.
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_phases.size() != 0)
			@(posedge clk);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (2 * cur_delay + 32) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_phase_delay(input logic [23:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cur_delay = v;
	endtask

	// Check every strobed phase against the oldest expectation.
	always @(posedge clk) begin
		bus_phase_t exp_ph;
		if (arst_n && strobe) begin
			if (pending_phases.size() == 0) begin
				$error("unexpected phase: reg_sel %0d nibble %0h enable %0d hold %0d last %0d",
					reg_sel, data_nibble, enable, hold_periods, last);
				mismatch_count++;
			end else begin
				exp_ph = pending_phases.pop_front();
				if (reg_sel !== exp_ph.reg_sel) begin
					$error("reg_sel: expected %0d, got %0d", exp_ph.reg_sel, reg_sel);
					mismatch_count++;
				end
				if (data_nibble !== exp_ph.nibble) begin
					$error("data_nibble: expected %0h, got %0h", exp_ph.nibble, data_nibble);
					mismatch_count++;
				end
				if (enable !== exp_ph.enable) begin
					$error("enable: expected %0d, got %0d", exp_ph.enable, enable);
					mismatch_count++;
				end
				if (hold_periods !== exp_ph.hold) begin
					$error("hold_periods: expected %0d, got %0d", exp_ph.hold, hold_periods);
					mismatch_count++;
				end
				if (last !== exp_ph.last) begin
					$error("last: expected %0d, got %0d", exp_ph.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		lcd_request_t r;
		int           n_phases;
		int           produced;
		int           cfg_round;
		int           pick;

		clk            = 1'b0;
		arst_n         = 1'b0;
		start          = 1'b0;
		command        = '0;
		byte_value     = '0;
		rs_select      = 1'b0;
		cursor_pos     = '0;
		line           = '0;
		number         = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		mismatch_count = 0;
		cycle_count    = 0;
		cur_delay      = DELAY_RESET;
		burst_left     = 0;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Walk the directed rows. The first runs at the reset delay; after it,
		// drop to the shortest period so the rest finishes quickly.
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_request(directed_rows[i], n_phases);
			if (i == 0) begin
				wait_idle();
				set_phase_delay(DELAY_MIN);
				cfg_we <= 1'b0;
			end
		end

		// Random part: mostly valid requests with random content, some noise.
		// Change the hold period after every 25 requests, touching the largest value once.
		produced  = 0;
		cfg_round = 0;
		while (produced < RANDOM_REQS) begin
			if (produced >= 25 * (cfg_round + 1)) begin
				cfg_round++;
				wait_idle();
				if (cfg_round == 2) begin
					set_phase_delay(DELAY_MAX);
					set_phase_delay(DELAY_MIN);
				end else begin
					set_phase_delay(24'($urandom_range(2, 4)));
				end
				cfg_we <= 1'b0;
			end
			r.byte_v     = 8'($urandom);
			r.rs         = 1'($urandom);
			r.pos        = 7'($urandom);
			r.ln         = 3'($urandom);
			r.num        = 16'($urandom);
			r.hand_typed = 1'b0;
			r.has_byte   = 1'b0;
			r.t_byte     = '0;
			r.t_rs       = 1'b0;
			r.t_long     = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				r.cmd = CMD_INIT;
			else if (pick < 20)
				r.cmd = CMD_CLEAR;
			else if (pick < 40)
				r.cmd = CMD_CURSOR;
			else if (pick < 60)
				r.cmd = CMD_CHAR;
			else if (pick < 75)
				r.cmd = CMD_NUMBER;
			else if (pick < 94)
				r.cmd = CMD_RAW;
			else
				r.cmd = ($urandom_range(0, 1) == 0) ? CMD_SPARE_6 : CMD_SPARE_7;
			send_request(r, n_phases);
			// every request counts, ignored ones included
			produced++;
		end

		wait_idle();
		if (mismatch_count == 0 && pending_phases.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
